>>> hdl/rmq_pkg.sv
// Shared widths, types and constants for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int unsigned DW        = 16;         // matrix entry and quaternion width
  localparam int unsigned RAD_W     = 18;         // signed radicand and trace width
  localparam int unsigned D_W       = 18;         // signed off-diagonal sum or difference
  localparam int unsigned MAG_W     = D_W - 1;    // magnitude of a sum or difference
  localparam int unsigned SQ_STEPS  = 15;         // one result bit per sqrt stage
  localparam int unsigned N_W       = 2 * SQ_STEPS; // sqrt operand width
  localparam int unsigned H_W       = 15;         // rounded pivot width
  localparam int unsigned DIV_STEPS = 15;         // one quotient bit per divider stage
  localparam int unsigned DV_W      = H_W + 1;    // divisor 2*h
  localparam int unsigned NUM_W     = N_W;        // dividend 2*|d|*4096 + h
  localparam int unsigned CMP_W     = DV_W + DIV_STEPS; // divisor at its top shift
  localparam int unsigned ONE_Q14   = 16384;

  // Component that carries the square root
  typedef enum logic [1:0] {
    PIV_X = 2'd0,
    PIV_Y = 2'd1,
    PIV_Z = 2'd2,
    PIV_W = 2'd3
  } pivot_e;

  // Side data that rides along with the sqrt pipeline
  typedef struct packed {
    pivot_e                pivot;
    logic signed [D_W-1:0] d0;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
  } prep_t;

  // Side data that rides along with the divider lanes
  typedef struct packed {
    pivot_e         pivot;
    logic [H_W-1:0] h;
  } piv_t;

endpackage

>>> hdl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion, fully pipelined.
//
//  Channel  Dir  Group    Payload
//  input    in   s_axis   tdata: r1c1 r1c2 r1c3 r2c1 r2c2 r2c3 r3c1 r3c2 r3c3
//  result   out  m_axis   tdata: quat_x quat_y quat_z quat_w, tuser: bad_input
//
// One request enters every cycle while the pipeline advances; the stages are 1 front stage, 15 sqrt
// stages plus rounding, divider setup plus 15 divider stages, and the output register.
// The whole pipeline advances together; it holds while a result waits unread.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3 (16 bits each)
  input  logic [9*rmq_pkg::DW-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each)
  output logic [4*rmq_pkg::DW-1:0]   m_axis_tdata,
  // bad_input
  output logic                       m_axis_tuser
);
  import rmq_pkg::*;

  localparam int unsigned DivLat = DIV_STEPS + 1;

  logic           en;
  logic           prep_vld, sq_vld;
  logic [N_W-1:0] prep_n;
  prep_t          prep_side, sq_side;
  logic [H_W-1:0] sq_h;

  logic signed [DW-1:0] lane0, lane1, lane2;

  piv_t piv_s [0:DivLat];
  logic vld_s [0:DivLat];

  logic [4*DW-1:0] out_d, out_q;
  logic            bad_d, bad_q, out_vld_q;
  logic [DW-1:0]   hx;

  // Global advance: move unless a finished result is still waiting
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  rmq_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .mat_i  (s_axis_tdata),
    .vld_o  (prep_vld),
    .n_o    (prep_n),
    .side_o (prep_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_vld),
    .n_i    (prep_n),
    .side_i (prep_side),
    .vld_o  (sq_vld),
    .h_o    (sq_h),
    .side_o (sq_side)
  );

  rmq_div u_div0 (.clk_i(clk_i), .en_i(en), .d_i(sq_side.d0), .h_i(sq_h), .q_o(lane0));
  rmq_div u_div1 (.clk_i(clk_i), .en_i(en), .d_i(sq_side.d1), .h_i(sq_h), .q_o(lane1));
  rmq_div u_div2 (.clk_i(clk_i), .en_i(en), .d_i(sq_side.d2), .h_i(sq_h), .q_o(lane2));

  // Pivot and root follow the divider lanes
  assign piv_s[0].pivot = sq_side.pivot;
  assign piv_s[0].h     = sq_h;
  assign vld_s[0]       = sq_vld;

  for (genvar k = 0; k < DivLat; k++) begin : g_dly
    piv_t piv_q;
    logic vld_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        piv_q <= piv_s[k];
      end
    end

    assign piv_s[k+1] = piv_q;
    assign vld_s[k+1] = vld_q;
  end

  // Place the root and the three quotients by pivot
  always_comb begin
    hx    = DW'(piv_s[DivLat].h);
    bad_d = piv_s[DivLat].h == '0;
    unique case (piv_s[DivLat].pivot)
      PIV_X:   out_d = {lane2, lane1, lane0, hx};
      PIV_Y:   out_d = {lane2, lane1, hx, lane0};
      PIV_Z:   out_d = {lane2, hx, lane1, lane0};
      PIV_W:   out_d = {hx, lane2, lane1, lane0};
      default: out_d = '0;
    endcase
    if (bad_d) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_s[DivLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
      bad_q <= bad_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = bad_q;

  // A flagged result carries all-zero components
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("flagged result with nonzero components");

  // Input is taken exactly when the pipeline advances
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow pipeline advance");

  // A stall freezes the divider-side valid bits
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_s[DivLat]) && $stable(vld_s[1]))
    else $error("pipeline moved during a stall");

endmodule

>>> hdl/rmq_prep.sv
// Front stage: trace, branch choice, radicand and off-diagonal terms.
`timescale 1ns / 1ps
module rmq_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [9*rmq_pkg::DW-1:0]      mat_i,
  output logic                          vld_o,
  output logic [rmq_pkg::N_W-1:0]       n_o,
  output rmq_pkg::prep_t                side_o
);
  import rmq_pkg::*;

  logic signed [RAD_W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [RAD_W-1:0] trace, rad;
  logic [N_W-1:0]          n_d, n_q;
  prep_t                   side_d, side_q;
  logic                    vld_q;

  // Unpack and sign-extend the entries
  always_comb begin
    m11 = RAD_W'($signed(mat_i[0*DW +: DW]));
    m12 = RAD_W'($signed(mat_i[1*DW +: DW]));
    m13 = RAD_W'($signed(mat_i[2*DW +: DW]));
    m21 = RAD_W'($signed(mat_i[3*DW +: DW]));
    m22 = RAD_W'($signed(mat_i[4*DW +: DW]));
    m23 = RAD_W'($signed(mat_i[5*DW +: DW]));
    m31 = RAD_W'($signed(mat_i[6*DW +: DW]));
    m32 = RAD_W'($signed(mat_i[7*DW +: DW]));
    m33 = RAD_W'($signed(mat_i[8*DW +: DW]));
  end

  // Branch choice, ordered as the trace test comes first
  always_comb begin
    trace = m11 + m22 + m33;
    priority if (!trace[RAD_W-1]) begin
      side_d.pivot = PIV_W;
      rad          = trace + RAD_W'(ONE_Q14);
      side_d.d0    = m23 - m32;
      side_d.d1    = m31 - m13;
      side_d.d2    = m12 - m21;
    end else if (m11 > m22 && m11 > m33) begin
      side_d.pivot = PIV_X;
      rad          = RAD_W'(ONE_Q14) + m11 - m22 - m33;
      side_d.d0    = m21 + m12;
      side_d.d1    = m31 + m13;
      side_d.d2    = m23 - m32;
    end else if (m22 > m33) begin
      side_d.pivot = PIV_Y;
      rad          = RAD_W'(ONE_Q14) + m22 - m11 - m33;
      side_d.d0    = m21 + m12;
      side_d.d1    = m32 + m23;
      side_d.d2    = m31 - m13;
    end else begin
      side_d.pivot = PIV_Z;
      rad          = RAD_W'(ONE_Q14) + m33 - m11 - m22;
      side_d.d0    = m13 + m31;
      side_d.d1    = m32 + m23;
      side_d.d2    = m12 - m21;
    end
    // sqrt operand is R*4096; a radicand that is not positive gives zero
    if (rad > 0) begin
      n_d = N_W'({rad[RAD_W-2:0], 12'b0});
    end else begin
      n_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      side_q <= side_d;
    end
  end

  assign vld_o  = vld_q;
  assign n_o    = n_q;
  assign side_o = side_q;

endmodule

>>> hdl/rmq_sqrt.sv
// Pipelined rounded integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [rmq_pkg::N_W-1:0] n_i,
  input  rmq_pkg::prep_t          side_i,
  output logic                    vld_o,
  output logic [rmq_pkg::H_W-1:0] h_o,
  output rmq_pkg::prep_t          side_o
);
  import rmq_pkg::*;

  logic [N_W-1:0] rem_s  [0:SQ_STEPS];
  logic [N_W-1:0] res_s  [0:SQ_STEPS];
  prep_t          side_s [0:SQ_STEPS];
  logic           vld_s  [0:SQ_STEPS];

  logic [H_W-1:0] h_q;
  prep_t          side_q;
  logic           vld_q;
  logic [N_W-1:0] res_rnd;

  assign rem_s[0]  = n_i;
  assign res_s[0]  = '0;
  assign side_s[0] = side_i;
  assign vld_s[0]  = vld_i;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [N_W-1:0] Bit = N_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [N_W-1:0] trial, rem_d, res_d, rem_q, res_q;
    prep_t          side_q;
    logic           vld_q;

    // One digit of the square root recurrence
    always_comb begin
      trial = res_s[k] + Bit;
      if (rem_s[k] >= trial) begin
        rem_d = rem_s[k] - trial;
        res_d = (res_s[k] >> 1) + Bit;
      end else begin
        rem_d = rem_s[k];
        res_d = res_s[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        res_q  <= res_d;
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign res_s[k+1]  = res_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  // Round to nearest: remainder n - res^2 above res means round up
  assign res_rnd = res_s[SQ_STEPS] + N_W'(rem_s[SQ_STEPS] > res_s[SQ_STEPS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_s[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q    <= res_rnd[H_W-1:0];
      side_q <= side_s[SQ_STEPS];
    end
  end

  assign vld_o  = vld_q;
  assign h_o    = h_q;
  assign side_o = side_q;

endmodule

>>> hdl/rmq_div.sv
// One divider lane: round(d*4096/h) with saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [rmq_pkg::D_W-1:0] d_i,
  input  logic [rmq_pkg::H_W-1:0]        h_i,
  output logic signed [rmq_pkg::DW-1:0]  q_o
);
  import rmq_pkg::*;

  logic [MAG_W-1:0] mag;
  logic [NUM_W-1:0] num_d;
  logic [DV_W-1:0]  dv_d;
  logic             ovf_d;

  logic [NUM_W-1:0]     rem_s [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_s [0:DIV_STEPS];
  logic [DV_W-1:0]      dv_s  [0:DIV_STEPS];
  logic                 neg_s [0:DIV_STEPS];
  logic                 ovf_s [0:DIV_STEPS];

  // Setup: dividend 2*|d|*4096 + h over divisor 2*h, overflow past 15 bits
  always_comb begin
    mag   = d_i[D_W-1] ? MAG_W'(-d_i) : MAG_W'(d_i);
    num_d = NUM_W'({mag, 13'b0}) + NUM_W'(h_i);
    dv_d  = {h_i, 1'b0};
    ovf_d = CMP_W'(num_d) >= {dv_d, {DIV_STEPS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_s[0] <= num_d;
      quo_s[0] <= '0;
      dv_s[0]  <= dv_d;
      neg_s[0] <= d_i[D_W-1];
      ovf_s[0] <= ovf_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int unsigned Sh = DIV_STEPS - 1 - k;
    logic [CMP_W-1:0] sub;
    logic             take;

    // Restoring division step for quotient bit Sh
    always_comb begin
      sub  = CMP_W'(dv_s[k]) << Sh;
      take = CMP_W'(rem_s[k]) >= sub;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= take ? NUM_W'(CMP_W'(rem_s[k]) - sub) : rem_s[k];
        quo_s[k+1] <= quo_s[k] | (DIV_STEPS'(take) << Sh);
        dv_s[k+1]  <= dv_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  // Sign and saturation
  always_comb begin
    priority if (ovf_s[DIV_STEPS]) begin
      q_o = neg_s[DIV_STEPS] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg_s[DIV_STEPS]) begin
      q_o = -$signed({1'b0, quo_s[DIV_STEPS]});
    end else begin
      q_o = $signed({1'b0, quo_s[DIV_STEPS]});
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the rotation matrix to quaternion pipeline: directed table plus random matrices.
`timescale 1ns / 1ps
module tb_top;
  import rmq_pkg::*;

  localparam int N_RANDOM   = 1930;
  localparam int LATENCY    = 34;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } quat_t;

  typedef struct {
    quat_t q;
    logic  bad;
  } quat_res_t;

  typedef logic signed [15:0] mat_t [9];

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [9*DW-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [4*DW-1:0]      m_axis_tdata;
  logic                 m_axis_tuser;

  quat_res_t quat_queue[$];
  int        fail_cnt = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;
  bit        stim_done = 1'b0;

  rotation_matrix_to_quaternion dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Nearest-integer square root
  function automatic longint sqrt_nearest(longint n);
    longint r;
    r = 0;
    for (int b = 20; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r += longint'(1) << b;
    if (n > r * r + r) r++;
    return r;
  endfunction

  // d*4096/h rounded half away from zero
  function automatic logic signed [15:0] scale_off(longint d, longint h);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (2 * mag * 4096 + h) / (2 * h);
    return sat16((d < 0) ? -q : q);
  endfunction

  function automatic quat_res_t predict_quat(mat_t m);
    quat_res_t res;
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, tr, rad, h, d0, d1, d2;
    pivot_e piv;
    logic signed [15:0] o0, o1, o2;
    a11 = m[0]; a12 = m[1]; a13 = m[2];
    a21 = m[3]; a22 = m[4]; a23 = m[5];
    a31 = m[6]; a32 = m[7]; a33 = m[8];
    tr = a11 + a22 + a33;
    if (tr >= 0) begin
      piv = PIV_W; rad = tr + ONE_Q14;
      d0 = a23 - a32; d1 = a31 - a13; d2 = a12 - a21;
    end else if (a11 > a22 && a11 > a33) begin
      piv = PIV_X; rad = ONE_Q14 + a11 - a22 - a33;
      d0 = a21 + a12; d1 = a31 + a13; d2 = a23 - a32;
    end else if (a22 > a33) begin
      piv = PIV_Y; rad = ONE_Q14 + a22 - a11 - a33;
      d0 = a21 + a12; d1 = a32 + a23; d2 = a31 - a13;
    end else begin
      piv = PIV_Z; rad = ONE_Q14 + a33 - a11 - a22;
      d0 = a13 + a31; d1 = a32 + a23; d2 = a12 - a21;
    end
    h = (rad > 0) ? sqrt_nearest(rad * 4096) : 0;
    res.q = '0;
    res.bad = (h == 0);
    if (h != 0) begin
      o0 = scale_off(d0, h); o1 = scale_off(d1, h); o2 = scale_off(d2, h);
      case (piv)
        PIV_X: begin res.q.x = sat16(h); res.q.y = o0; res.q.z = o1; res.q.w = o2; end
        PIV_Y: begin res.q.y = sat16(h); res.q.x = o0; res.q.z = o1; res.q.w = o2; end
        PIV_Z: begin res.q.z = sat16(h); res.q.x = o0; res.q.y = o1; res.q.w = o2; end
        default: begin res.q.w = sat16(h); res.q.x = o0; res.q.y = o1; res.q.z = o2; end
      endcase
    end
    return res;
  endfunction

  // Send one request, holding valid across back-to-back items
  task automatic send_matrix(mat_t m);
    logic [9*DW-1:0] packed_m;
    for (int k = 0; k < 9; k++) packed_m[k*16 +: 16] = m[k];
    while (!no_idle && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    quat_queue.push_back(predict_quat(m));
    @(negedge clk_i);
  endtask

  function automatic mat_t diag_mat(int a, int b, int c);
    mat_t m;
    foreach (m[k]) m[k] = '0;
    m[0] = 16'(a); m[4] = 16'(b); m[8] = 16'(c);
    return m;
  endfunction

  // Entries in -16384..16384 half the time; otherwise fully random or near full scale
  function automatic mat_t rand_mat();
    mat_t m;
    int mode;
    mode = $urandom_range(9);
    foreach (m[k]) begin
      if (mode < 3) m[k] = 16'($urandom);
      else if (mode < 5) m[k] = ($urandom_range(1)) ? 16'sh7fff - 16'($urandom_range(15))
                                                  : 16'sh8000 + 16'($urandom_range(15));
      else m[k] = 16'($signed($urandom_range(32768)) - 16384);
    end
    if (mode == 9) begin
      m[0] = 16'(-$urandom_range(16384)); m[4] = m[0]; m[8] = m[0];
    end
    return m;
  endfunction

  // Stimulus
  initial begin
    mat_t m;
    quat_res_t known;
    typedef struct {
      int d[9];
      bit has_known;
      logic signed [15:0] kx, ky, kz, kw;
    } dir_row_t;
    dir_row_t dir_table[] = '{
      '{'{16384,0,0, 0,16384,0, 0,0,16384}, 1, 0, 0, 0, 16384},    // identity
      '{'{0,0,0, 0,0,0, 0,0,0}, 1, 0, 0, 0, 8192},                  // zero matrix
      '{'{16384,0,0, 0,-16384,0, 0,0,-16384}, 1, 16384, 0, 0, 0},   // 180 about x
      '{'{-16384,0,0, 0,16384,0, 0,0,-16384}, 1, 0, 16384, 0, 0},   // 180 about y
      '{'{-16384,0,0, 0,-16384,0, 0,0,16384}, 1, 0, 0, 16384, 0},   // 180 about z
      '{'{-16384,0,0, 0,-16384,0, 0,0,-16384}, 0, 0, 0, 0, 0},      // ties -> z pivot
      '{'{-16384,5,7, 0,-16384,0, 9,0,-16384}, 0, 0, 0, 0, 0},
      '{'{0,-16384,0, 16384,0,0, 0,0,16384}, 0, 0, 0, 0, 0},        // 90 about z
      '{'{32767,32767,32767, 32767,32767,32767, 32767,32767,32767}, 0, 0, 0, 0, 0},
      '{'{-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768},
        0, 0, 0, 0, 0},
      '{'{-32768,32767,-32768, 32767,-1,32767, -32768,32767,-1}, 0, 0, 0, 0, 0},
      '{'{-1,-32768,32767, 32767,-32768,-32768, 32767,32767,-32768}, 0, 0, 0, 0, 0},
      '{'{-32768,32767,32767, 32767,-32768,32767, 32767,32767,-32767}, 0, 0, 0, 0, 0},
      '{'{-5461,-32768,-32768, 32767,-5461,-32768, -32768,32767,-5462}, 0, 0, 0, 0, 0},
      '{'{0,0,0, 0,0,0, 0,0,-1}, 0, 0, 0, 0, 0},                    // trace just negative
      '{'{-1,0,0, 0,-1,0, 0,0,-1}, 0, 0, 0, 0, 0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_table[r]) begin
      foreach (m[k]) m[k] = 16'(dir_table[r].d[k]);
      send_matrix(m);
      if (dir_table[r].has_known) begin
        known.q.x = dir_table[r].kx; known.q.y = dir_table[r].ky;
        known.q.z = dir_table[r].kz; known.q.w = dir_table[r].kw;
        known.bad = 1'b0;
        quat_queue[$] = known;
      end
    end

    // Random part; hold off once until the pipe drains
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 900);
      if (i == 1200) begin
        s_axis_tvalid <= 1'b0;
        while (quat_queue.size() != 0) @(negedge clk_i);
      end
      send_matrix(rand_mat());
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side stalls
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Check results and run the watchdog
  always @(posedge clk_i) begin
    quat_res_t want;
    quat_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (quat_queue.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d w=%0d", got.x, got.y, got.z, got.w);
        fail_cnt++;
      end else begin
        want = quat_queue.pop_front();
        if (got.x !== want.q.x) begin
          $error("quat_x expected %0d got %0d", want.q.x, got.x); fail_cnt++;
        end
        if (got.y !== want.q.y) begin
          $error("quat_y expected %0d got %0d", want.q.y, got.y); fail_cnt++;
        end
        if (got.z !== want.q.z) begin
          $error("quat_z expected %0d got %0d", want.q.z, got.z); fail_cnt++;
        end
        if (got.w !== want.q.w) begin
          $error("quat_w expected %0d got %0d", want.q.w, got.w); fail_cnt++;
        end
        if (m_axis_tuser !== want.bad) begin
          $error("bad_input expected %0d got %0d", want.bad, m_axis_tuser); fail_cnt++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // End of run; the watchdog also covers a stall while requests are still being sent
  initial begin
    wait (stim_done || idle_cycles >= IDLE_LIMIT);
    while (quat_queue.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (LATENCY + 10) @(posedge clk_i);
      if (fail_cnt == 0 && quat_queue.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule
